// ===== rtl/stereo_biquad_filter_top_defines.svh =====
// Assertion macros for the stereo biquad filter checker.
// Needs signals named clk and arst_n where it is used.
`ifndef STEREO_BIQUAD_FILTER_TOP_DEFINES_SVH
`define STEREO_BIQUAD_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sbq_pkg.sv =====
// Shared types and constants for the stereo biquad filter.
// No dependencies; the modules and interfaces refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package sbq_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 28;
	localparam int CHANNELS  = 2;
	localparam int CFG_IDX_W = 3;

	localparam int FRAC_W  = COEF_W - 4;
	localparam int PROD_W  = SAMPLE_W + COEF_W;
	localparam int ACC_W   = PROD_W + 3;
	localparam int SHIFT_W = ACC_W - FRAC_W;

	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(longint'(1) <<< (FRAC_W - 1));
	localparam logic signed [SHIFT_W-1:0] SAT_MAX =
		SHIFT_W'((longint'(1) <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [SHIFT_W-1:0] SAT_MIN =
		SHIFT_W'(-(longint'(1) <<< (SAMPLE_W - 1)));
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// pass-through items after the filter comes back from bypass
	localparam logic [1:0] PRIME_LEN = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	// history update strobes for one channel
	typedef struct packed {
		logic upd_filt;
		logic upd_prime;
	} lane_ctl_t;

endpackage

// ===== rtl/sbq_ifs.sv =====
// Valid/ready channel interfaces: sample input, filtered result, coefficient writes.
// Depends on sbq_pkg for the field widths.
`timescale 1ns / 1ps

interface sbq_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [sbq_pkg::SAMPLE_W-1:0] left_in;
	logic signed [sbq_pkg::SAMPLE_W-1:0] right_in;
	logic                                bypass;

	modport source (output valid, left_in, right_in, bypass, input ready);
	modport sink (input valid, left_in, right_in, bypass, output ready);
endinterface

interface sbq_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [sbq_pkg::SAMPLE_W-1:0] left_out;
	logic signed [sbq_pkg::SAMPLE_W-1:0] right_out;
	logic                                was_filtered;

	modport source (output valid, left_out, right_out, was_filtered, input ready);
	modport sink (input valid, left_out, right_out, was_filtered, output ready);
endinterface

interface sbq_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sbq_pkg::CFG_IDX_W-1:0]        index;
	logic signed [sbq_pkg::COEF_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sbq_lane.sv =====
// One channel of the biquad: five-tap multiply-accumulate, rounding, saturation
// and the x/y history registers. Depends on sbq_pkg.
`timescale 1ns / 1ps

module sbq_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbq_pkg::lane_ctl_t                  ctl,
	input  sbq_pkg::coef_set_t                  coef,
	input  logic signed [sbq_pkg::SAMPLE_W-1:0] x,
	output logic signed [sbq_pkg::SAMPLE_W-1:0] y_filt
);

	logic signed [sbq_pkg::SAMPLE_W-1:0] xh1_q, xh2_q, yh1_q, yh2_q;
	logic signed [sbq_pkg::PROD_W-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [sbq_pkg::ACC_W-1:0]    acc;
	logic signed [sbq_pkg::SHIFT_W-1:0]  sh;

	assign p_b0 = x * coef.b0;
	assign p_b1 = xh1_q * coef.b1;
	assign p_b2 = xh2_q * coef.b2;
	assign p_a1 = yh1_q * coef.a1;
	assign p_a2 = yh2_q * coef.a2;

	assign acc = sbq_pkg::ACC_W'(p_b0) + sbq_pkg::ACC_W'(p_b1) + sbq_pkg::ACC_W'(p_b2)
		- sbq_pkg::ACC_W'(p_a1) - sbq_pkg::ACC_W'(p_a2) + sbq_pkg::ROUND;

	// arithmetic shift by the fraction width: keep the upper bits
	assign sh = acc[sbq_pkg::ACC_W-1:sbq_pkg::FRAC_W];

	always_comb begin
		if (sh > sbq_pkg::SAT_MAX) begin
			y_filt = sbq_pkg::SMP_MAX;
		end else if (sh < sbq_pkg::SAT_MIN) begin
			y_filt = sbq_pkg::SMP_MIN;
		end else begin
			y_filt = sh[sbq_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh1_q <= '0;
			xh2_q <= '0;
			yh1_q <= '0;
			yh2_q <= '0;
		end else if (ctl.upd_filt) begin
			xh2_q <= xh1_q;
			xh1_q <= x;
			yh2_q <= yh1_q;
			yh1_q <= y_filt;
		end else if (ctl.upd_prime) begin
			// x1 stays stale while priming
			xh2_q <= '0;
			yh2_q <= yh1_q;
			yh1_q <= x;
		end
	end

endmodule

// ===== rtl/stereo_biquad_filter_top.sv =====
// Stereo biquad filter: one stereo pair per sample transfer, one result per pair.
// A pair is accepted on every clock when results are taken; the pair passes the input
// register, then the output register, before its result is valid. The rate is set by the
// output-history feedback, which closes through the per-channel multiply-accumulate.
// A held result does not stop the next pair from entering the input register.
// Coefficient writes are always ready and apply from the next cycle; write them only
// while no pair is in flight. After bypass, two pairs pass through unfiltered to refill
// the output history before filtering restarts.
// Depends on sbq_pkg, sbq_ifs and sbq_lane.
`timescale 1ns / 1ps

module stereo_biquad_filter_top (
	input  logic         clk,
	input  logic         arst_n,
	sbq_sample_if.sink   sample,
	sbq_result_if.source result,
	sbq_cfg_if.sink      cfg
);

	sbq_pkg::coef_set_t coef_q;

	logic                                valid_s1;
	logic signed [sbq_pkg::SAMPLE_W-1:0] left_s1, right_s1;
	logic                                bypass_s1;

	logic       active_q;
	logic [1:0] prime_q;
	logic [1:0] prime_eff;
	logic       do_prime, do_filt, adv;

	logic                                out_valid_q;
	logic signed [sbq_pkg::SAMPLE_W-1:0] left_q, right_q;
	logic                                filt_q;

	sbq_pkg::lane_ctl_t                  lane_ctl;
	logic signed [sbq_pkg::SAMPLE_W-1:0] lane_x [sbq_pkg::CHANNELS];
	logic signed [sbq_pkg::SAMPLE_W-1:0] lane_y [sbq_pkg::CHANNELS];
	logic signed [sbq_pkg::SAMPLE_W-1:0] right_y;

	// coefficient writes; indexes past the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			unique case (sbq_pkg::coef_idx_t'(cfg.index))
				sbq_pkg::COEF_B0: coef_q.b0 <= cfg.data;
				sbq_pkg::COEF_B1: coef_q.b1 <= cfg.data;
				sbq_pkg::COEF_B2: coef_q.b2 <= cfg.data;
				sbq_pkg::COEF_A1: coef_q.a1 <= cfg.data;
				sbq_pkg::COEF_A2: coef_q.a2 <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage 1 moves to the output register when that is free or being emptied
	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			left_s1   <= sample.left_in;
			right_s1  <= sample.right_in;
			bypass_s1 <= sample.bypass;
		end
	end

	// mode of the item in stage 1
	assign prime_eff = active_q ? prime_q : sbq_pkg::PRIME_LEN;
	assign do_prime  = !bypass_s1 && (prime_eff != 2'd0);
	assign do_filt   = !bypass_s1 && (prime_eff == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			prime_q  <= 2'd0;
		end else if (adv) begin
			if (bypass_s1) begin
				active_q <= 1'b0;
				prime_q  <= 2'd0;
			end else begin
				active_q <= 1'b1;
				if (do_prime) begin
					prime_q <= prime_eff - 2'd1;
				end
			end
		end
	end

	assign lane_ctl.upd_filt  = adv && do_filt;
	assign lane_ctl.upd_prime = adv && do_prime;

	for (genvar c = 0; c < sbq_pkg::CHANNELS; c++) begin : g_lane
		if (c == 0) begin : g_left
			assign lane_x[c] = left_s1;
		end else begin : g_right
			assign lane_x[c] = right_s1;
		end

		sbq_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.coef   (coef_q),
			.x      (lane_x[c]),
			.y_filt (lane_y[c])
		);
	end

	if (sbq_pkg::CHANNELS > 1) begin : g_stereo
		assign right_y = do_filt ? lane_y[sbq_pkg::CHANNELS-1] : right_s1;
	end else begin : g_mono
		assign right_y = '0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_q  <= do_filt ? lane_y[0] : left_s1;
			right_q <= right_y;
			filt_q  <= do_filt;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.left_out     = left_q;
	assign result.right_out    = right_q;
	assign result.was_filtered = filt_q;

endmodule

// ===== rtl/sbq_checker.sv =====
// Port-level checks for stereo_biquad_filter_top, attached by bind.
// Depends on sbq_pkg and the macros in stereo_biquad_filter_top_defines.svh.
`timescale 1ns / 1ps
`include "stereo_biquad_filter_top_defines.svh"

module sbq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_valid,
	input logic                                s_ready,
	input logic                                r_valid,
	input logic                                r_ready,
	input logic signed [sbq_pkg::SAMPLE_W-1:0] r_left,
	input logic signed [sbq_pkg::SAMPLE_W-1:0] r_right,
	input logic                                r_filt
);

	logic [2:0] occ_q;
	logic       s_xfer, r_xfer;

	assign s_xfer = s_valid && s_ready;
	assign r_xfer = r_valid && r_ready;

	// pairs taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 3'd0;
		end else begin
			occ_q <= occ_q + {2'b00, s_xfer} - {2'b00, r_xfer};
		end
	end

	`SBQ_ASSERT_NEXT(a_result_hold, r_valid && !r_ready, r_valid && $stable(r_left) && $stable(r_right) && $stable(r_filt), "result changed while stalled")
	`SBQ_ASSERT_NOW(a_occ_max, 1'b1, occ_q <= 3'd2, "more than two pairs in flight")
	`SBQ_ASSERT_NOW(a_no_phantom, r_valid, occ_q != 3'd0, "result with no pair in flight")
	`SBQ_ASSERT_NOW(a_ready_empty, !r_valid, s_ready, "input stalled with empty output")

endmodule

bind stereo_biquad_filter_top sbq_checker u_sbq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_left  (result.left_out),
	.r_right (result.right_out),
	.r_filt  (result.was_filtered)
);

// ===== bench/tb_stereo_biquad_filter_top.sv =====
// Testbench for stereo_biquad_filter_top: a directed table, then random coefficient phases.
// Each sample transfer is predicted in-bench and results are checked in order.
// Depends on sbq_pkg and sbq_ifs from the RTL.
`timescale 1ns / 1ps

module tb_stereo_biquad_filter_top;
	import sbq_pkg::*;

	localparam int  CLK_HALF_NS   = 5;
	localparam int  TIMEOUT_NS    = 2_000_000;
	localparam int  DRAIN_SLACK   = 4;
	localparam int  LONG_HOLD     = 200;
	localparam int  NUM_PHASES    = 8;
	localparam int  PHASE_ITEMS   = 235;
	localparam int  DIR_ROWS      = 30;

	localparam logic signed [COEF_W-1:0] Q_ONE  = 28'sh1000000;
	localparam logic signed [COEF_W-1:0] Q_HALF = 28'sh0800000;
	localparam logic signed [COEF_W-1:0] Q_MAX  = 28'sh7FFFFFF;
	localparam logic signed [COEF_W-1:0] Q_MIN  = 28'sh8000000;

	// indexes past the coefficient list; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] IDX_FIRST_SPARE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_LAST_SPARE  = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       filt;
	} pair_out_t;

	typedef struct packed {
		bit        typed;
		pair_out_t val;
	} typed_out_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e                  kind;
		logic [CFG_IDX_W-1:0]       idx;
		logic signed [COEF_W-1:0]   coef;
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
		bit                         byp;
		bit                         typed;
		logic signed [SAMPLE_W-1:0] el;
		logic signed [SAMPLE_W-1:0] er;
		bit                         ef;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sbq_sample_if sample_ch ();
	sbq_result_if result_ch ();
	sbq_cfg_if    cfg_ch ();

	stereo_biquad_filter_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	logic signed [COEF_W-1:0]   coef_reg [5];
	logic signed [SAMPLE_W-1:0] x_d1 [2];
	logic signed [SAMPLE_W-1:0] x_d2 [2];
	logic signed [SAMPLE_W-1:0] y_d1 [2];
	logic signed [SAMPLE_W-1:0] y_d2 [2];
	bit                         filt_on = 1'b1;
	int                         prime_left = 0;

	pair_out_t  expected_outs [$];
	typed_out_t typed_outs [$];
	int         mismatch_cnt = 0;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;

	// directed rows: zero coefficients after reset, unity gain, tie rounding,
	// saturation at both coefficient extremes, bypass, priming and bypass during priming
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM, COEF_B0, 0, 0, 0, 0, 1, 0, 0, 1},
		'{ROW_ITEM, COEF_B0, 0, SMP_MAX, SMP_MIN, 0, 1, 0, 0, 1},
		'{ROW_CFG, COEF_B0, Q_ONE, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, SMP_MAX, SMP_MIN, 0, 1, SMP_MAX, SMP_MIN, 1},
		'{ROW_ITEM, COEF_B0, 0, -1, 1, 0, 1, -1, 1, 1},
		'{ROW_CFG, COEF_B0, Q_HALF, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, 1, -1, 0, 1, 1, 0, 1},
		'{ROW_ITEM, COEF_B0, 0, 3, -3, 0, 1, 2, -1, 1},
		'{ROW_CFG, COEF_B0, Q_MAX, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, SMP_MAX, SMP_MIN, 0, 1, SMP_MAX, SMP_MIN, 1},
		'{ROW_CFG, COEF_B0, Q_MIN, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, SMP_MAX, SMP_MIN, 0, 1, SMP_MIN, SMP_MAX, 1},
		'{ROW_ITEM, COEF_B0, 0, 123, -5, 1, 1, 123, -5, 0},
		'{ROW_ITEM, COEF_B0, 0, 7, 9, 0, 1, 7, 9, 0},
		'{ROW_ITEM, COEF_B0, 0, -1, 1, 0, 1, -1, 1, 0},
		'{ROW_ITEM, COEF_B0, 0, 100, -100, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, SMP_MAX, SMP_MIN, 1, 1, SMP_MAX, SMP_MIN, 0},
		'{ROW_ITEM, COEF_B0, 0, 5, 6, 0, 1, 5, 6, 0},
		'{ROW_ITEM, COEF_B0, 0, 24'h2AAAAA, 24'hD55555, 1, 1, 24'h2AAAAA, 24'hD55555, 0},
		'{ROW_ITEM, COEF_B0, 0, 8, -8, 0, 1, 8, -8, 0},
		'{ROW_ITEM, COEF_B0, 0, 4, 4, 0, 1, 4, 4, 0},
		'{ROW_ITEM, COEF_B0, 0, 1000, -1000, 0, 0, 0, 0, 0},
		'{ROW_CFG, COEF_B1, Q_HALF, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, COEF_B2, -Q_HALF, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, COEF_A1, Q_MIN, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, COEF_A2, Q_MAX, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, IDX_FIRST_SPARE, Q_MAX, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, IDX_LAST_SPARE, Q_MIN, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, SMP_MAX, SMP_MIN, 0, 0, 0, 0, 0},
		'{ROW_ITEM, COEF_B0, 0, 12345, -54321, 0, 0, 0, 0, 0}
	};

	initial begin
		for (int ch = 0; ch < 2; ch++) begin
			x_d1[ch] = '0;
			x_d2[ch] = '0;
			y_d1[ch] = '0;
			y_d2[ch] = '0;
		end
		for (int k = 0; k < 5; k++) coef_reg[k] = '0;
	end

	always #(CLK_HALF_NS) clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

	// one channel of the biquad: exact sum, round half up, saturate
	function automatic logic signed [SAMPLE_W-1:0] biquad_lane(int ch,
			logic signed [SAMPLE_W-1:0] x);
		longint acc;
		acc = longint'(x) * longint'(coef_reg[COEF_B0])
			+ longint'(x_d1[ch]) * longint'(coef_reg[COEF_B1])
			+ longint'(x_d2[ch]) * longint'(coef_reg[COEF_B2])
			- longint'(y_d1[ch]) * longint'(coef_reg[COEF_A1])
			- longint'(y_d2[ch]) * longint'(coef_reg[COEF_A2]);
		acc = acc + (longint'(1) <<< (FRAC_W - 1));
		acc = acc >>> FRAC_W;
		if (acc > longint'(SMP_MAX)) acc = longint'(SMP_MAX);
		if (acc < longint'(SMP_MIN)) acc = longint'(SMP_MIN);
		return acc[SAMPLE_W-1:0];
	endfunction

	function automatic pair_out_t biquad_predict(logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r, bit byp);
		pair_out_t o;
		logic signed [SAMPLE_W-1:0] x [2];
		logic signed [SAMPLE_W-1:0] y [2];
		x[0] = l;
		x[1] = r;
		y[0] = l;
		y[1] = r;
		o.filt = 1'b0;
		if (byp) begin
			filt_on = 1'b0;
			prime_left = 0;
		end else begin
			if (!filt_on) begin
				filt_on = 1'b1;
				prime_left = int'(PRIME_LEN);
			end
			if (prime_left > 0) begin
				// x_d1 stays stale on purpose
				for (int ch = 0; ch < CHANNELS; ch++) begin
					x_d2[ch] = '0;
					y_d2[ch] = y_d1[ch];
					y_d1[ch] = x[ch];
				end
				prime_left--;
			end else begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					y[ch] = biquad_lane(ch, x[ch]);
					y_d2[ch] = y_d1[ch];
					y_d1[ch] = y[ch];
					x_d2[ch] = x_d1[ch];
					x_d1[ch] = x[ch];
				end
				o.filt = 1'b1;
			end
		end
		o.left = y[0];
		o.right = y[1];
		return o;
	endfunction

	// results first: a result leaving at this edge always belongs to an older pair
	always @(posedge clk) begin
		pair_out_t  got;
		pair_out_t  want;
		pair_out_t  pred;
		typed_out_t note;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index <= COEF_A2)
				coef_reg[cfg_ch.index] = cfg_ch.data;
			if (result_ch.valid && result_ch.ready) begin
				got.left = result_ch.left_out;
				got.right = result_ch.right_out;
				got.filt = result_ch.was_filtered;
				if (expected_outs.size() == 0) begin
					$display("%0t: result with none expected: L=%0d R=%0d F=%0b",
						$time, got.left, got.right, got.filt);
					mismatch_cnt++;
				end else begin
					want = expected_outs.pop_front();
					if (got.left !== want.left || got.right !== want.right
							|| got.filt !== want.filt) begin
						$display("%0t: expected L=%0d R=%0d F=%0b, got L=%0d R=%0d F=%0b",
							$time, want.left, want.right, want.filt,
							got.left, got.right, got.filt);
						mismatch_cnt++;
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				pred = biquad_predict(sample_ch.left_in, sample_ch.right_in,
					sample_ch.bypass);
				note = typed_outs.pop_front();
				expected_outs.push_back(note.typed ? note.val : pred);
			end
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic push_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
			bit byp, bit typed, pair_out_t val);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		typed_outs.push_back('{typed, val});
		sample_ch.valid <= 1'b1;
		sample_ch.left_in <= l;
		sample_ch.right_in <= r;
		sample_ch.bypass <= byp;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		wait (expected_outs.size() == 0);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	// leaves cfg valid high; the caller lowers it
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2, 3: return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] wild_coef();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4: return COEF_W'(int'($urandom_range(0, int'(Q_ONE))) - int'(Q_HALF));
			default: return COEF_W'($urandom());
		endcase
	endfunction

	initial begin
		pair_out_t                  dir_val;
		logic signed [COEF_W-1:0]   cval;
		bit                         byp;
		int                         byp_run;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.left_in = '0;
		sample_ch.right_in = '0;
		sample_ch.bypass = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		byp_run = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				cfg_write(dir_rows[i].idx, dir_rows[i].coef);
				cfg_ch.valid <= 1'b0;
			end else begin
				dir_val = '{dir_rows[i].el, dir_rows[i].er, dir_rows[i].ef};
				push_sample(dir_rows[i].l, dir_rows[i].r, dir_rows[i].byp,
					dir_rows[i].typed, dir_val);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			// even phases keep the filter near stable, odd ones drive it hard
			for (int k = int'(COEF_B0); k <= int'(COEF_A2); k++) begin
				if (ph % 2 == 1)
					cval = wild_coef();
				else if (k <= int'(COEF_B2))
					cval = COEF_W'(int'($urandom_range(0, 2 * int'(Q_ONE))) - int'(Q_ONE));
				else
					cval = COEF_W'(int'($urandom_range(0, int'(Q_HALF))) - int'(Q_HALF) / 2);
				cfg_write(CFG_IDX_W'(k), cval);
			end
			if (ph % 3 == 2)
				cfg_write(CFG_IDX_W'($urandom_range(IDX_FIRST_SPARE, IDX_LAST_SPARE)),
					COEF_W'($urandom()));
			cfg_ch.valid <= 1'b0;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == NUM_PHASES - 1) begin
					tx_gaps = 1'b0;
					rx_gaps = 1'b0;
				end else if (i % 40 == 0) begin
					tx_gaps = $urandom_range(0, 3) != 0;
					rx_gaps = $urandom_range(0, 3) != 0;
				end
				// sink stalls for a long stretch while pairs keep coming
				if (ph == 1 && i == 0) begin
					hold_req = 1'b1;
					tx_gaps = 1'b0;
				end
				if (ph == 4 && i == PHASE_ITEMS / 2)
					wait_idle();
				if (byp_run > 0) begin
					byp = 1'b1;
					byp_run--;
				end else if ($urandom_range(0, 11) == 0) begin
					byp = 1'b1;
					byp_run = $urandom_range(0, 2);
				end else begin
					byp = 1'b0;
				end
				push_sample(rand_sample(), rand_sample(), byp, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatch_cnt == 0 && expected_outs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
